### sv/cpio_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the processor I/O port block.
// No dependencies.
package cpio_pkg;

  typedef enum logic [1:0] {
    KIND_RD_PORT = 2'd0,
    KIND_RD_DIR  = 2'd1,
    KIND_WR_PORT = 2'd2,
    KIND_WR_DIR  = 2'd3
  } kind_t;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned CYC_W  = 64;

  localparam logic [DT_W-1:0] DISCHARGE_RESET = 24'd350000;

  localparam logic [7:0] PULLUP_LOW  = 8'h07;
  localparam logic [7:0] PULLUP_BIT4 = 8'h10;
  localparam logic [7:0] CAP_BIT3    = 8'h08;
  localparam logic [7:0] CAP_BIT6    = 8'h40;
  localparam logic [7:0] CAP_BIT7    = 8'h80;

  localparam int unsigned MOTOR_IDX = 5;
  localparam int unsigned BIT3_IDX  = 3;
  localparam int unsigned BIT6_IDX  = 6;
  localparam int unsigned BIT7_IDX  = 7;

  localparam logic ADDR_PORT = 1'b1;
  localparam logic ADDR_DIR  = 1'b0;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        write_value;
    logic [CYC_W-1:0]  cycle_now;
    logic              play_key_down;
    logic [7:0]        video_bus_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       motor_update;
    logic       motor_on;
    logic       ram_write_valid;
    logic       ram_write_address;
    logic [7:0] ram_write_data;
    logic       banking_changed;
  } result_t;

endpackage

### sv/cpio_cfg.sv
`timescale 1ns / 1ps
// APB-style register port holding the discharge time.
// Depends on cpio_pkg.
module cpio_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpio_pkg::CFG_AW-1:0]  paddr,
  input  logic [cpio_pkg::CFG_DW-1:0]  pwdata,
  output logic [cpio_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output logic [cpio_pkg::DT_W-1:0]    discharge_time
);

  logic [cpio_pkg::DT_W-1:0] discharge_r;
  logic                      hit;

  assign pready = 1'b1;
  assign hit    = (paddr[cpio_pkg::CFG_AW-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discharge_r <= cpio_pkg::DISCHARGE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      discharge_r <= pwdata[cpio_pkg::DT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(cpio_pkg::CFG_DW - cpio_pkg::DT_W){1'b0}}, discharge_r};
    end
  end

  assign discharge_time = discharge_r;

endmodule

### sv/cpio_port_state.sv
`timescale 1ns / 1ps
// Port latch, direction register and floating-bit state, with the result logic
// for one access. Depends on cpio_pkg.
module cpio_port_state (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  cpio_pkg::item_t            item,
  input  logic [cpio_pkg::DT_W-1:0]  discharge_time,
  output cpio_pkg::result_t          result
);

  logic [7:0]                 latch_r, latch_nxt;
  logic [7:0]                 dir_r, dir_nxt;
  logic                       flt3_r, flt3_nxt;
  logic [cpio_pkg::CYC_W-1:0] dl6_r, dl6_nxt;
  logic [cpio_pkg::CYC_W-1:0] dl7_r, dl7_nxt;
  logic [cpio_pkg::CYC_W-1:0] deadline;
  logic [7:0]                 pins;
  logic [7:0]                 falling;
  logic [7:0]                 nd;

  assign nd       = item.write_value;
  assign falling  = dir_r & ~nd & latch_r;
  assign deadline = item.cycle_now + {{(cpio_pkg::CYC_W - cpio_pkg::DT_W){1'b0}},
                                      discharge_time};

  always_comb begin
    pins = cpio_pkg::PULLUP_LOW;
    if (!item.play_key_down) pins = pins | cpio_pkg::PULLUP_BIT4;
    if (flt3_r)                pins = pins | cpio_pkg::CAP_BIT3;
    if (dl6_r > item.cycle_now) pins = pins | cpio_pkg::CAP_BIT6;
    if (dl7_r > item.cycle_now) pins = pins | cpio_pkg::CAP_BIT7;
  end

  always_comb begin
    latch_nxt = latch_r;
    dir_nxt   = dir_r;
    flt3_nxt  = flt3_r;
    dl6_nxt   = dl6_r;
    dl7_nxt   = dl7_r;
    result    = '0;
    case (item.kind)
      cpio_pkg::KIND_RD_PORT: begin
        result.read_value = (latch_r & dir_r) | (pins & ~dir_r);
      end
      cpio_pkg::KIND_RD_DIR: begin
        result.read_value = dir_r;
      end
      cpio_pkg::KIND_WR_PORT: begin
        latch_nxt = nd;
        if (dir_r[cpio_pkg::MOTOR_IDX]) begin
          result.motor_update = 1'b1;
          result.motor_on     = ~nd[cpio_pkg::MOTOR_IDX];
        end
        result.ram_write_valid   = 1'b1;
        result.ram_write_address = cpio_pkg::ADDR_PORT;
        result.ram_write_data    = item.video_bus_byte;
        result.banking_changed   = 1'b1;
      end
      cpio_pkg::KIND_WR_DIR: begin
        dir_nxt = nd;
        if (nd[cpio_pkg::BIT3_IDX])      flt3_nxt = 1'b0;
        if (falling[cpio_pkg::BIT3_IDX]) flt3_nxt = 1'b1;
        if (nd[cpio_pkg::BIT6_IDX])      dl6_nxt  = '0;
        if (falling[cpio_pkg::BIT6_IDX]) dl6_nxt  = deadline;
        if (nd[cpio_pkg::BIT7_IDX])      dl7_nxt  = '0;
        if (falling[cpio_pkg::BIT7_IDX]) dl7_nxt  = deadline;
        result.ram_write_valid   = 1'b1;
        result.ram_write_address = cpio_pkg::ADDR_DIR;
        result.ram_write_data    = item.video_bus_byte;
        result.banking_changed   = 1'b1;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
      dir_r   <= '0;
      flt3_r  <= 1'b0;
      dl6_r   <= '0;
      dl7_r   <= '0;
    end else if (fire) begin
      latch_r <= latch_nxt;
      dir_r   <= dir_nxt;
      flt3_r  <= flt3_nxt;
      dl6_r   <= dl6_nxt;
      dl7_r   <= dl7_nxt;
    end
  end

endmodule

### sv/cpu_io_port_with_floating_bits.sv
`timescale 1ns / 1ps
// Processor I/O port top level: input register, port state and result register.
// Depends on cpio_pkg, cpio_cfg and cpio_port_state.
//
// Usage:
//   Access items arrive on the in_ stream: the access kind on in_tuser, the
//   written byte, cycle count, play key and video bus byte packed in in_tdata.
//   Each item yields exactly one result on the out_ stream.
//   An accepted item is first held in the input register; the port logic then
//   evaluates it and updates its state as the item moves into the result
//   register, which drives out_tvalid. One item per cycle is sustained while
//   out_tready stays high; the per-item work is a 64-bit deadline compare and
//   add plus bit logic.
//   When the receiver stalls, the result register holds and the input register
//   fills; in_tready falls once both are occupied and rises as soon as the
//   result register drains. No item is lost or repeated.
//   Reset (rst_n low at a clock edge) empties both registers, clears the latch,
//   direction, floating state and deadlines, and restores the discharge time
//   to 350000 cycle_now counts. The user writes it through the cfg_ port at
//   byte address 0 only while the stream is idle; the block does not enforce it.
module cpu_io_port_with_floating_bits (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] write_value, [71:8] cycle_now, [72] play_key_down,
  // [80:73] video_bus_byte, [87:81] zero
  input  logic [cpio_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] read_value, [8] motor_update, [9] motor_on, [10] ram_write_valid,
  // [11] ram_write_address, [19:12] ram_write_data, [20] banking_changed,
  // [23:21] zero
  output logic [cpio_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cpio_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [cpio_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [cpio_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  logic                       s1_valid_r;
  cpio_pkg::item_t            s1_item_r;
  logic                       out_valid_r;
  cpio_pkg::result_t          out_r;
  cpio_pkg::result_t          result;
  logic                       s1_adv;
  logic                       fire;
  logic                       in_xfer;
  logic [cpio_pkg::DT_W-1:0]  discharge_time;

  cpio_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .discharge_time (discharge_time)
  );

  cpio_port_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (s1_item_r),
    .discharge_time (discharge_time),
    .result         (result)
  );

  assign s1_adv    = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv)    out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.kind           <= cpio_pkg::kind_t'(in_tuser);
      s1_item_r.write_value    <= in_tdata[7:0];
      s1_item_r.cycle_now      <= in_tdata[71:8];
      s1_item_r.play_key_down  <= in_tdata[72];
      s1_item_r.video_bus_byte <= in_tdata[80:73];
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.banking_changed, out_r.ram_write_data,
                       out_r.ram_write_address, out_r.ram_write_valid,
                       out_r.motor_on, out_r.motor_update, out_r.read_value};

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost an item under stall");

  a_wr_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.ram_write_valid == out_r.banking_changed)
    else $error("write flags disagree");

  a_motor_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.motor_update |-> out_r.ram_write_address == cpio_pkg::ADDR_PORT)
    else $error("motor update outside a port write");

  a_rd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.ram_write_valid |->
      !out_r.motor_update && !out_r.motor_on && out_r.ram_write_data == 8'h00)
    else $error("read result carries write fields");

  a_wr_noread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.ram_write_valid |-> out_r.read_value == 8'h00)
    else $error("write result carries read data");

endmodule
